// File: src/grid_ray_dda_walk_macros.svh
// Assertion macros used by the checker file of the grid ray walk.
`ifndef GRID_RAY_DDA_WALK_MACROS_SVH
`define GRID_RAY_DDA_WALK_MACROS_SVH

// Checked only while out of reset.
`define GDDA_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("grid ray walk assertion failed");

// Checked on every edge, reset included.
`define GDDA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("grid ray walk assertion failed");

`endif

// File: src/gdda_pkg.sv
// Shared constants, types and helper functions of the grid ray walk.
package gdda_pkg;

    localparam int MAP_ROWS   = 64;
    localparam int MAP_COLS   = 64;
    localparam int MAP_DEPTH  = MAP_ROWS * MAP_COLS;
    localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);
    localparam int CELL_W     = 6;
    localparam int DIST_W     = 32;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_CAST  = 1'b1;

    localparam logic       SIDE_X = 1'b0;
    localparam logic       SIDE_Y = 1'b1;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_EAST  = 2'd3;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic check;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic start_done;
        logic step_out;
        logic wall_hit;
    } status_t;

    function automatic logic [MAP_ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] row,
                                                        input logic [CELL_W-1:0] col);
        cell_addr = MAP_ADDR_W'(row) * MAP_ADDR_W'(MAP_COLS) + MAP_ADDR_W'(col);
    endfunction

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        sat_add = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
    endfunction

endpackage

// File: src/gdda_ctrl.sv
// Control state machine of the grid ray walk.
module gdda_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic             s_func,
    input  gdda_pkg::status_t status,
    output gdda_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_func == gdda_pkg::FUNC_WRITE || status.start_done) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                state_next = status.step_out ? ST_FINISH : ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                state_next = status.wall_hit ? ST_FINISH : ST_STEP;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/gdda_dpath.sv
// Datapath of the grid ray walk: wall map memory, walk registers and result register.
module gdda_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gdda_pkg::cmd_t                cmd,
    output gdda_pkg::status_t             status,
    input  logic                          s_func,
    input  logic [gdda_pkg::CELL_W-1:0]   s_cell_x,
    input  logic [gdda_pkg::CELL_W-1:0]   s_cell_y,
    input  logic                          s_wall_bit,
    input  logic                          s_step_x_neg,
    input  logic                          s_step_y_neg,
    input  logic [gdda_pkg::DIST_W-1:0]   s_side_dist_x,
    input  logic [gdda_pkg::DIST_W-1:0]   s_side_dist_y,
    input  logic [gdda_pkg::DIST_W-1:0]   s_delta_dist_x,
    input  logic [gdda_pkg::DIST_W-1:0]   s_delta_dist_y,
    output logic [gdda_pkg::CELL_W-1:0]   m_hit_x,
    output logic [gdda_pkg::CELL_W-1:0]   m_hit_y,
    output logic                          m_hit_side,
    output logic [1:0]                    m_wall_face,
    output logic [gdda_pkg::DIST_W-1:0]   m_end_dist_x,
    output logic [gdda_pkg::DIST_W-1:0]   m_end_dist_y,
    output logic                          m_wall_found
);

    logic map_mem [gdda_pkg::MAP_DEPTH];

    logic [gdda_pkg::MAP_ADDR_W-1:0] clr_cnt_reg;
    logic                            rd_reg;

    logic [gdda_pkg::CELL_W-1:0] row_reg, col_reg;
    logic [gdda_pkg::DIST_W-1:0] sdx_reg, sdy_reg, ddx_reg, ddy_reg;
    logic                        xneg_reg, yneg_reg, side_reg, found_reg, write_reg;

    logic [gdda_pkg::CELL_W-1:0] out_x_reg, out_y_reg;
    logic [gdda_pkg::DIST_W-1:0] out_dx_reg, out_dy_reg;
    logic [1:0]                  out_face_reg;
    logic                        out_side_reg, out_found_reg;

    logic                        in_grid;
    logic                        x_first;
    logic                        row_edge, col_edge;
    logic [gdda_pkg::CELL_W-1:0] row_step, col_step;
    logic [gdda_pkg::CELL_W-1:0] row_next, col_next;
    logic [1:0]                  face;

    assign in_grid = (int'(s_cell_x) < gdda_pkg::MAP_ROWS) &&
                     (int'(s_cell_y) < gdda_pkg::MAP_COLS);

    assign x_first  = (sdx_reg < sdy_reg);
    assign row_edge = xneg_reg ? (row_reg == '0)
                               : (int'(row_reg) >= gdda_pkg::MAP_ROWS - 1);
    assign col_edge = yneg_reg ? (col_reg == '0)
                               : (int'(col_reg) >= gdda_pkg::MAP_COLS - 1);
    assign row_step = xneg_reg ? row_reg - 1'b1 : row_reg + 1'b1;
    assign col_step = yneg_reg ? col_reg - 1'b1 : col_reg + 1'b1;
    assign row_next = x_first ? row_step : row_reg;
    assign col_next = x_first ? col_reg : col_step;

    assign status.clear_last = (clr_cnt_reg == gdda_pkg::MAP_ADDR_W'(gdda_pkg::MAP_DEPTH - 1));
    assign status.start_done = !in_grid;
    assign status.step_out   = x_first ? row_edge : col_edge;
    assign status.wall_hit   = rd_reg;

    always_comb begin
        if (side_reg == gdda_pkg::SIDE_X) begin
            face = xneg_reg ? gdda_pkg::FACE_NORTH : gdda_pkg::FACE_SOUTH;
        end else begin
            face = yneg_reg ? gdda_pkg::FACE_WEST : gdda_pkg::FACE_EAST;
        end
    end

    // The map is only ever read on a step command of a cast.
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            map_mem[clr_cnt_reg] <= 1'b0;
        end else if (cmd.load && s_func == gdda_pkg::FUNC_WRITE && in_grid) begin
            map_mem[gdda_pkg::cell_addr(s_cell_x, s_cell_y)] <= s_wall_bit;
        end
        if (cmd.step) begin
            rd_reg <= map_mem[gdda_pkg::cell_addr(row_next, col_next)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_reg   <= s_cell_x;
            col_reg   <= s_cell_y;
            sdx_reg   <= s_side_dist_x;
            sdy_reg   <= s_side_dist_y;
            ddx_reg   <= s_delta_dist_x;
            ddy_reg   <= s_delta_dist_y;
            xneg_reg  <= s_step_x_neg;
            yneg_reg  <= s_step_y_neg;
            side_reg  <= gdda_pkg::SIDE_X;
            found_reg <= 1'b0;
            write_reg <= (s_func == gdda_pkg::FUNC_WRITE);
        end else if (cmd.step) begin
            if (x_first) begin
                sdx_reg  <= gdda_pkg::sat_add(sdx_reg, ddx_reg);
                side_reg <= gdda_pkg::SIDE_X;
            end else begin
                sdy_reg  <= gdda_pkg::sat_add(sdy_reg, ddy_reg);
                side_reg <= gdda_pkg::SIDE_Y;
            end
            if (!status.step_out) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end else if (cmd.check) begin
            found_reg <= rd_reg;
        end
    end

    // A write item returns a word of all zeros.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (write_reg) begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_side_reg  <= 1'b0;
                out_face_reg  <= '0;
                out_dx_reg    <= '0;
                out_dy_reg    <= '0;
                out_found_reg <= 1'b0;
            end else begin
                out_x_reg     <= row_reg;
                out_y_reg     <= col_reg;
                out_side_reg  <= side_reg;
                out_face_reg  <= face;
                out_dx_reg    <= sdx_reg;
                out_dy_reg    <= sdy_reg;
                out_found_reg <= found_reg;
            end
        end
    end

    assign m_hit_x      = out_x_reg;
    assign m_hit_y      = out_y_reg;
    assign m_hit_side   = out_side_reg;
    assign m_wall_face  = out_face_reg;
    assign m_end_dist_x = out_dx_reg;
    assign m_end_dist_y = out_dy_reg;
    assign m_wall_found = out_found_reg;

endmodule

// File: src/grid_ray_dda_walk.sv
// Top level of the grid ray walk: control state machine and datapath.
// The block keeps a 64 x 64 wall map and takes one word at a time. A write word
// sets one cell, and its result goes through the finish state to the output
// register. A cast word walks the grid one cell per step, and every step inside
// the grid waits in a check state for the registered read of the map memory. A cast
// goes to the finish state after the check of the step that enters a wall, or
// straight from a step that would leave the grid. A walk enters at most 126 cells.
// A finished result waits in the output register while the next word is accepted.
// After reset the map is cleared one cell per cycle, all 4096 cells, during which
// s_ready stays low.
module grid_ray_dda_walk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [gdda_pkg::CELL_W-1:0]   s_cell_x,
    input  logic [gdda_pkg::CELL_W-1:0]   s_cell_y,
    input  logic                          s_wall_bit,
    input  logic                          s_step_x_neg,
    input  logic                          s_step_y_neg,
    input  logic [gdda_pkg::DIST_W-1:0]   s_side_dist_x,
    input  logic [gdda_pkg::DIST_W-1:0]   s_side_dist_y,
    input  logic [gdda_pkg::DIST_W-1:0]   s_delta_dist_x,
    input  logic [gdda_pkg::DIST_W-1:0]   s_delta_dist_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gdda_pkg::CELL_W-1:0]   m_hit_x,
    output logic [gdda_pkg::CELL_W-1:0]   m_hit_y,
    output logic                          m_hit_side,
    output logic [1:0]                    m_wall_face,
    output logic [gdda_pkg::DIST_W-1:0]   m_end_dist_x,
    output logic [gdda_pkg::DIST_W-1:0]   m_end_dist_y,
    output logic                          m_wall_found
);

    gdda_pkg::cmd_t    cmd;
    gdda_pkg::status_t status;

    gdda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    gdda_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_func         (s_func),
        .s_cell_x       (s_cell_x),
        .s_cell_y       (s_cell_y),
        .s_wall_bit     (s_wall_bit),
        .s_step_x_neg   (s_step_x_neg),
        .s_step_y_neg   (s_step_y_neg),
        .s_side_dist_x  (s_side_dist_x),
        .s_side_dist_y  (s_side_dist_y),
        .s_delta_dist_x (s_delta_dist_x),
        .s_delta_dist_y (s_delta_dist_y),
        .m_hit_x        (m_hit_x),
        .m_hit_y        (m_hit_y),
        .m_hit_side     (m_hit_side),
        .m_wall_face    (m_wall_face),
        .m_end_dist_x   (m_end_dist_x),
        .m_end_dist_y   (m_end_dist_y),
        .m_wall_found   (m_wall_found)
    );

endmodule

// File: src/gdda_checker.sv
// Port-level assertion checker of the grid ray walk and its bind.
`include "grid_ray_dda_walk_macros.svh"

module gdda_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [gdda_pkg::CELL_W-1:0] m_hit_x,
    input logic                        m_hit_side,
    input logic [1:0]                  m_wall_face,
    input logic                        m_wall_found
);

    // The map clearing pass keeps the input side closed right after reset.
    `GDDA_ASSERT_ALWAYS(a_clear_after_reset, !aresetn |=> !s_ready)

    // Words are taken one at a time.
    `GDDA_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready)

    // The face always belongs to the axis that was crossed last.
    `GDDA_ASSERT(a_face_on_axis, m_valid |-> (m_wall_face[1] == m_hit_side))

    // A stalled result word holds.
    `GDDA_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable({m_hit_x, m_wall_found}))

endmodule

bind grid_ray_dda_walk gdda_checker u_gdda_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hit_x      (m_hit_x),
    .m_hit_side   (m_hit_side),
    .m_wall_face  (m_wall_face),
    .m_wall_found (m_wall_found)
);
